// ===== rtl/qs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_pkg: shared types and constants for the quicksort engine
// Widths, channel payloads, stack entry layout and sequencer states.
// ----------------------------------------------------------------------------
package qs_pkg;
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = IDX_W + 1;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    typedef struct packed {
        data_t value;
        logic  final_item;
    } load_item_t;

    typedef struct packed {
        data_t sorted_value;
        logic  last_result;
        logic  overflow;
    } sorted_item_t;

    typedef struct packed {
        idx_t lo;
        idx_t hi;
    } range_t;

    localparam int RANGE_W = $bits(range_t);

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_POP,
        S_PIV,
        S_PIVW,
        S_SCAN,
        S_SCANW,
        S_SWAPA,
        S_SWAPB,
        S_SWAPW,
        S_FINA,
        S_FINB,
        S_PUSH,
        S_OUT,
        S_OUTW
    } state_t;
endpackage

// ===== rtl/qs_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_stream_if: valid/ready channel
// Carries one payload per transfer.
// ----------------------------------------------------------------------------
interface qs_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/qs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_ram: generic single-port RAM
// One access per cycle, registered read data; a write reads back the old word.
// ----------------------------------------------------------------------------
module qs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/quicksort_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_engine: collect, sort and replay a set of signed values
// Lomuto quicksort over a single-port element RAM with a range stack RAM.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// in_ch   | in  | value, final_item
// out_ch  | out | sorted_value, last_result, overflow
//
// Loading accepts one item per cycle. After the final item the sort runs over
// the single element RAM port, scanning each element against the pivot and
// swapping smaller ones forward; each partition then places the pivot and
// pushes the subranges still to sort. Output stalls hold each result. Reset
// clears count, stack pointer and flag; RAMs need no clearing.
// The input is not ready from the final transfer until the last result goes.
// ----------------------------------------------------------------------------
module quicksort_engine
    import qs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    qs_stream_if.sink   in_ch,
    qs_stream_if.source out_ch
);
    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    cnt_t   sp_reg, sp_next;
    logic   drop_reg, drop_next;
    idx_t   lo_reg, lo_next, hi_reg, hi_next, j_reg, j_next, nx_reg, nx_next;
    data_t  piv_reg, piv_next, a_reg, a_next;
    logic   ov_reg, ov_next;
    logic   pushed_reg, pushed_next;
    data_t  oval_reg, oval_next;
    logic   olast_reg, olast_next, oflag_reg, oflag_next;

    logic   ram_we;
    idx_t   ram_addr;
    data_t  ram_wdata, ram_rdata;
    logic   stk_we;
    idx_t   stk_addr;
    range_t stk_wdata, stk_rdata;

    qs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );
    qs_ram #(.WIDTH(RANGE_W), .DEPTH(DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata)
    );

    logic in_xfer, out_xfer, less;
    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_xfer = out_ch.valid && out_ch.ready;
    // the shared comparator: scanned element against the pivot
    assign less     = ram_rdata < piv_reg;

    assign in_ch.ready            = (state_reg == S_LOAD);
    assign out_ch.valid           = ov_reg;
    assign out_ch.payload.sorted_value = oval_reg;
    assign out_ch.payload.last_result  = olast_reg;
    assign out_ch.payload.overflow     = oflag_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:  if (in_xfer && in_ch.payload.final_item) state_next = S_START;
            S_START: state_next = (count_reg < cnt_t'(2)) ? S_OUT : S_POP;
            S_POP:   state_next = (sp_reg == '0) ? S_OUT : S_PIV;
            S_PIV:   state_next = S_PIVW;
            S_PIVW:  state_next = S_SCAN;
            S_SCAN:  state_next = (j_reg == hi_reg) ? S_FINA : S_SCANW;
            S_SCANW: state_next = less ? S_SWAPA : S_SCAN;
            S_SWAPA: state_next = S_SWAPB;
            S_SWAPB: state_next = S_SWAPW;
            S_SWAPW: state_next = S_SCAN;
            S_FINA:  state_next = S_FINB;
            S_FINB:  state_next = S_PUSH;
            S_PUSH:  state_next = pushed_reg ? S_POP : S_PUSH;
            S_OUT:   if (!ov_reg || out_xfer)
                         state_next = (count_reg == '0) ? S_LOAD : S_OUTW;
            S_OUTW:  state_next = S_OUT;
            default: state_next = S_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next = count_reg; sp_next = sp_reg; drop_next = drop_reg;
        lo_next = lo_reg; hi_next = hi_reg; j_next = j_reg; nx_next = nx_reg;
        piv_next = piv_reg; a_next = a_reg; pushed_next = pushed_reg;
        ov_next = ov_reg; oval_next = oval_reg; olast_next = olast_reg;
        oflag_next = oflag_reg;
        ram_we = 1'b0; ram_addr = j_reg; ram_wdata = a_reg;
        stk_we = 1'b0; stk_addr = idx_t'(sp_reg - cnt_t'(1)); stk_wdata = '0;
        if (out_xfer) ov_next = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                ram_addr  = count_reg[IDX_W-1:0];
                ram_wdata = in_ch.payload.value;
                if (in_xfer)
                begin
                    if (count_reg < cnt_t'(DEPTH))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + cnt_t'(1);
                    end
                    else
                        drop_next = 1'b1;
                end
            end
            S_START:
            begin
                // push the whole set
                stk_we    = 1'b1;
                stk_addr  = '0;
                stk_wdata = '{lo: '0, hi: idx_t'(count_reg - cnt_t'(1))};
                sp_next   = (count_reg < cnt_t'(2)) ? sp_reg : cnt_t'(1);
                j_next    = '0;
            end
            S_POP:
            begin
                // stack RAM read issued; data lands next cycle
                if (sp_reg != '0) sp_next = sp_reg - cnt_t'(1);
                j_next = '0;
            end
            S_PIV:
            begin
                lo_next  = stk_rdata.lo;
                hi_next  = stk_rdata.hi;
                ram_addr = stk_rdata.hi;
                j_next   = stk_rdata.lo;
                nx_next  = stk_rdata.lo;
            end
            S_PIVW:
            begin
                piv_next = ram_rdata;
                ram_addr = j_reg;
            end
            S_SCAN:
                ram_addr = (j_reg == hi_reg) ? nx_reg : j_reg;
            S_SCANW:
            begin
                ram_addr = nx_reg;
                if (less)
                    a_next = ram_rdata;
                else
                    j_next = j_reg + idx_t'(1);
            end
            S_SWAPA:
            begin
                // store[j] <= store[nx]
                ram_addr = j_reg;
                ram_we   = 1'b1;
                ram_wdata = ram_rdata;
            end
            S_SWAPB:
            begin
                ram_addr  = nx_reg;
                ram_we    = 1'b1;
                ram_wdata = a_reg;
                nx_next   = nx_reg + idx_t'(1);
                j_next    = j_reg + idx_t'(1);
            end
            S_SWAPW:
                ram_addr = j_reg;
            S_FINA:
            begin
                // store[hi] <= store[nx]; store[nx] <= pivot
                ram_addr  = hi_reg;
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            S_FINB:
            begin
                ram_addr    = nx_reg;
                ram_we      = 1'b1;
                ram_wdata   = piv_reg;
                pushed_next = 1'b0;
            end
            S_PUSH:
            begin
                // upper range pushed first, lower range after it
                stk_addr = sp_reg[IDX_W-1:0];
                if (!pushed_reg)
                begin
                    if ({1'b0, nx_reg} + cnt_t'(1) < {1'b0, hi_reg})
                    begin
                        stk_we    = 1'b1;
                        stk_wdata = '{lo: nx_reg + idx_t'(1), hi: hi_reg};
                        sp_next   = sp_reg + cnt_t'(1);
                    end
                end
                else if ({1'b0, nx_reg} > {1'b0, lo_reg} + cnt_t'(1))
                begin
                    stk_we    = 1'b1;
                    stk_wdata = '{lo: lo_reg, hi: nx_reg - idx_t'(1)};
                    sp_next   = sp_reg + cnt_t'(1);
                end
                pushed_next = 1'b1;
            end
            S_OUT:
            begin
                ram_addr = j_reg;
                if (!ov_reg || out_xfer)
                begin
                    if (count_reg == '0)
                    begin
                        drop_next = 1'b0;
                        sp_next   = '0;
                    end
                end
            end
            S_OUTW:
            begin
                ov_next    = 1'b1;
                oval_next  = ram_rdata;
                olast_next = (count_reg == cnt_t'(1));
                oflag_next = drop_reg;
                count_next = count_reg - cnt_t'(1);
                j_next     = j_reg + idx_t'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            sp_reg    <= '0;
            drop_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            pushed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sp_reg    <= sp_next;
            drop_reg  <= drop_next;
            ov_reg    <= ov_next;
            pushed_reg <= pushed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next; hi_reg <= hi_next; j_reg <= j_next; nx_reg <= nx_next;
        piv_reg <= piv_next; a_reg <= a_next;
        oval_reg <= oval_next; olast_reg <= olast_next; oflag_reg <= oflag_next;
    end
endmodule

// ===== rtl/qs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_checker: port-level checks for the quicksort engine
// Watches both channels and the ordering of results.
// ----------------------------------------------------------------------------
module qs_checker
    import qs_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input data_t sorted_value,
    input logic  last_result
);
    logic  have_prev_reg;
    data_t prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            have_prev_reg <= 1'b0;
        else if (out_valid && out_ready)
            have_prev_reg <= !last_result;
    end

    always_ff @(posedge clk)
    begin
        if (out_valid && out_ready)
            prev_reg <= sorted_value;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sorted_value))
        else $error("result dropped while stalled");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && have_prev_reg |-> prev_reg <= sorted_value)
        else $error("results out of order");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input open while results pending");

    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_result |=> in_ready)
        else $error("input not reopened after last result");
endmodule

bind quicksort_engine qs_checker u_qs_checker (
    .clk(clk), .rst_n(rst_n),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sorted_value(out_ch.payload.sorted_value),
    .last_result(out_ch.payload.last_result)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the quicksort engine
// Streams sets of signed values in, predicts the ascending replay of each set
// (with the last-result mark and the dropped-item flag) and checks every
// output transfer in order, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top
    import qs_pkg::*;
;
    // Predicts the sorted replay of each collected set and holds the queue
    // of results still owed by the engine.
    class sort_scoreboard;
        data_t        held_values[DEPTH];
        int           held_count;
        bit           lost_items;
        sorted_item_t owed_results[$];
        int           failures;

        function new();
            held_count = 0;
            lost_items = 0;
            failures   = 0;
        endfunction

        // Note one accepted input transfer; on the final one, queue the set.
        function void note_load(load_item_t item);
            data_t key;
            int    j;
            sorted_item_t r;
            if (held_count < DEPTH)
            begin
                held_values[held_count] = item.value;
                held_count++;
            end
            else
            begin
                lost_items = 1;
            end
            if (!item.final_item)
                return;
            // Ascending order is unique up to equal values, which look alike.
            for (int i = 1; i < held_count; i++)
            begin
                key = held_values[i];
                j = i - 1;
                while (j >= 0 && held_values[j] > key)
                begin
                    held_values[j + 1] = held_values[j];
                    j--;
                end
                held_values[j + 1] = key;
            end
            for (int k = 0; k < held_count; k++)
            begin
                r.sorted_value = held_values[k];
                r.last_result  = (k == held_count - 1);
                r.overflow     = lost_items;
                owed_results.push_back(r);
            end
            held_count = 0;
            lost_items = 0;
        endfunction

        // Compare one output transfer against the oldest owed result.
        function void check_result(sorted_item_t got);
            sorted_item_t want;
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: sorted_value %0d", got.sorted_value);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            if (got.sorted_value !== want.sorted_value)
            begin
                $error("sorted_value: expected %0d, actual %0d",
                       want.sorted_value, got.sorted_value);
                failures++;
            end
            if (got.last_result !== want.last_result)
            begin
                $error("last_result: expected %0b, actual %0b",
                       want.last_result, got.last_result);
                failures++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0b, actual %0b",
                       want.overflow, got.overflow);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;     // set for the last part of the run: no idling
    int   sent;

    qs_stream_if #(.payload_t(load_item_t))   in_ch();
    qs_stream_if #(.payload_t(sorted_item_t)) out_ch();

    sort_scoreboard sb;

    quicksort_engine i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop: far beyond the slowest correct run (worst-case sorts
    // of full sets plus every stall).
    initial
    begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drive the output-side ready: random stall bursts, none once the
    // run is calm.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 3);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Check every output transfer; valid and ready are sampled as the
    // engine saw them at this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.payload);
    end

    // Send one item: hold valid until the transfer, with an optional idle
    // burst ahead of it.
    task automatic send_item(data_t value, logic fin);
        load_item_t item;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item.value      = value;
        item.final_item = fin;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= item;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_load(item);
        sent++;
    endtask

    function automatic data_t pick_value();
        case ($urandom_range(0, 5))
            0: return data_t'($urandom_range(0, 15)) - 8;
            1: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            2: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            default: return data_t'($urandom);
        endcase
    endfunction

    // Send a whole set of n items; shape 1 ascending, 2 descending,
    // 3 all equal, otherwise random content.
    task automatic send_set(int n, int shape);
        data_t v;
        data_t base;
        base = pick_value();
        for (int i = 0; i < n; i++)
        begin
            case (shape)
                1: v = base + i;
                2: v = base - i;
                3: v = base;
                default: v = pick_value();
            endcase
            send_item(v, i == n - 1);
        end
    endtask

    initial
    begin
        int waited;
        sb    = new();
        calm  = 0;
        sent  = 0;
        rst_n = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes in one set, two lone elements, duplicates.
        send_item({1'b0, {(DATA_WIDTH-1){1'b1}}}, 1'b0);
        send_item({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b0);
        send_item({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b1);
        send_item({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b1);
        send_item({1'b0, {(DATA_WIDTH-1){1'b1}}}, 1'b1);
        send_set(2, 1);
        send_set(2, 2);
        send_set(4, 3);
        send_set(8, 0);

        // Random sets, mostly small; a few full, sorted and overflowing ones.
        while (sent < 470)
        begin
            if (sent > 400)
                calm = 1;
            case ($urandom_range(0, 19))
                0: send_set(DEPTH, $urandom_range(0, 2));
                1: send_set(DEPTH + $urandom_range(1, 6), 0);
                default: send_set($urandom_range(1, 16), $urandom_range(0, 5));
            endcase
        end
        in_ch.valid <= 1'b0;

        // Drain: wait for every owed result, then let the engine settle.
        waited = 0;
        while (sb.owed_results.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.owed_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
